>>> hdl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared constants of the WebSocket frame deframer: parse phase codes,
// opcodes and header length codes.
// ----------------------------------------------------------------------------
package wsd_pkg;

	// Parse phase codes. Codes above PH_DATA act like PH_HDR1.
	localparam logic [2:0] PH_HDR1   = 3'd0;
	localparam logic [2:0] PH_HDR2   = 3'd1;
	localparam logic [2:0] PH_EXTLEN = 3'd2;
	localparam logic [2:0] PH_KEY    = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;

	localparam logic [3:0] OP_TEXT   = 4'd1;
	localparam logic [3:0] OP_BINARY = 4'd2;
	localparam logic [3:0] OP_MASK   = 4'hf;

	localparam logic [1:0] KIND_TEXT   = 2'd1;
	localparam logic [1:0] KIND_BINARY = 2'd2;

	localparam logic [6:0] LEN7_MAX_SHORT = 7'd125;
	localparam logic [6:0] LEN7_EXT16     = 7'd126;

	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [2:0] KEY_BYTES   = 3'd4;

	typedef logic [7:0] byte_t;

endpackage

>>> hdl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// A payload byte passes from the input register to the result register.
// Throughput: one byte per cycle; the input stalls only while the result
// register holds an item that the sink is stalling.
// Reset (arst_n low, asynchronous): parser waits for a first header byte,
// all header state cleared, both registers empty.
// Parses frame headers, unmasks text and binary payload bytes and marks the
// last byte of each frame; other frames are consumed silently.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  logic       in_valid,
	output logic       in_stall,
	output logic [7:0] payload_byte,
	output logic [1:0] frame_kind,
	output logic       last_of_frame,
	output logic       out_valid,
	input  logic       out_stall
);

	// Input register.
	wsd_pkg::byte_t byte_s1;
	logic           valid_s1;

	// Parser state.
	logic [2:0]  phase_q;
	logic [3:0]  opcode_q;
	logic        masked_q;
	logic [3:0]  ext_left_q;
	logic [63:0] remaining_q;
	logic [31:0] key_q;
	logic [2:0]  key_left_q;
	logic [1:0]  pay_phase_q;

	logic [2:0]  phase_n;
	logic [3:0]  opcode_n;
	logic        masked_n;
	logic [3:0]  ext_left_n;
	logic [63:0] remaining_n;
	logic [31:0] key_n;
	logic [2:0]  key_left_n;
	logic [1:0]  pay_phase_n;

	// Result register.
	logic [7:0] payload_q;
	logic [1:0] kind_q;
	logic       last_q;
	logic       out_valid_q;

	logic        advance;
	logic        emit;
	logic [6:0]  len7;
	logic [63:0] rem_shifted;
	logic [3:0]  ext_left_dec;
	logic [31:0] key_shifted;
	logic [2:0]  key_left_dec;
	logic [7:0]  key_byte;
	logic [7:0]  data_byte;
	logic        data_last;
	logic        kind_ok;

	// Stage 1 moves on unless the result register is full and stalled.
	assign advance  = !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;

	assign len7         = byte_s1[6:0];
	assign rem_shifted  = {remaining_q[55:0], byte_s1};
	assign ext_left_dec = ext_left_q - {3'd0, (ext_left_q != 4'd0)};
	assign key_shifted  = {key_q[23:0], byte_s1};
	assign key_left_dec = key_left_q - {2'd0, (key_left_q != 3'd0)};
	assign data_last    = (remaining_q <= 64'd1);
	assign kind_ok      = (opcode_q == wsd_pkg::OP_TEXT) || (opcode_q == wsd_pkg::OP_BINARY);

	always_comb begin
		unique case (pay_phase_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	assign data_byte = byte_s1 ^ (masked_q ? key_byte : 8'd0);

	always_comb begin
		phase_n     = phase_q;
		opcode_n    = opcode_q;
		masked_n    = masked_q;
		ext_left_n  = ext_left_q;
		remaining_n = remaining_q;
		key_n       = key_q;
		key_left_n  = key_left_q;
		pay_phase_n = pay_phase_q;
		emit        = 1'b0;
		unique case (phase_q)
			wsd_pkg::PH_HDR2: begin
				masked_n = byte_s1[7];
				if (len7 <= wsd_pkg::LEN7_MAX_SHORT) begin
					remaining_n = {57'd0, len7};
					ext_left_n  = 4'd0;
					if (byte_s1[7]) begin
						key_left_n = wsd_pkg::KEY_BYTES;
						phase_n    = wsd_pkg::PH_KEY;
					end else begin
						pay_phase_n = 2'd0;
						phase_n     = (len7 == 7'd0) ? wsd_pkg::PH_HDR1 : wsd_pkg::PH_DATA;
					end
				end else begin
					remaining_n = 64'd0;
					ext_left_n  = (len7 == wsd_pkg::LEN7_EXT16) ? wsd_pkg::EXT16_BYTES
					                                            : wsd_pkg::EXT64_BYTES;
					phase_n     = wsd_pkg::PH_EXTLEN;
				end
			end
			wsd_pkg::PH_EXTLEN: begin
				remaining_n = rem_shifted;
				ext_left_n  = ext_left_dec;
				if (ext_left_dec == 4'd0) begin
					if (masked_q) begin
						key_left_n = wsd_pkg::KEY_BYTES;
						phase_n    = wsd_pkg::PH_KEY;
					end else begin
						pay_phase_n = 2'd0;
						phase_n     = (rem_shifted == 64'd0) ? wsd_pkg::PH_HDR1
						                                     : wsd_pkg::PH_DATA;
					end
				end
			end
			wsd_pkg::PH_KEY: begin
				key_n      = key_shifted;
				key_left_n = key_left_dec;
				if (key_left_dec == 3'd0) begin
					pay_phase_n = 2'd0;
					phase_n     = (remaining_q == 64'd0) ? wsd_pkg::PH_HDR1
					                                     : wsd_pkg::PH_DATA;
				end
			end
			wsd_pkg::PH_DATA: begin
				remaining_n = remaining_q - {63'd0, (remaining_q != 64'd0)};
				pay_phase_n = pay_phase_q + 2'd1;
				if (data_last) begin
					phase_n = wsd_pkg::PH_HDR1;
				end
				emit = kind_ok;
			end
			default: begin
				opcode_n = byte_s1[3:0] & wsd_pkg::OP_MASK;
				phase_n  = wsd_pkg::PH_HDR2;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= wsd_pkg::PH_HDR1;
			opcode_q    <= 4'd0;
			masked_q    <= 1'b0;
			ext_left_q  <= 4'd0;
			remaining_q <= 64'd0;
			key_q       <= 32'd0;
			key_left_q  <= 3'd0;
			pay_phase_q <= 2'd0;
		end else if (valid_s1 && advance) begin
			phase_q     <= phase_n;
			opcode_q    <= opcode_n;
			masked_q    <= masked_n;
			ext_left_q  <= ext_left_n;
			remaining_q <= remaining_n;
			key_q       <= key_n;
			key_left_q  <= key_left_n;
			pay_phase_q <= pay_phase_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance && emit) begin
			payload_q <= data_byte;
			kind_q    <= opcode_q[1:0];
			last_q    <= data_last;
		end
	end

	assign payload_byte  = payload_q;
	assign frame_kind    = kind_q;
	assign last_of_frame = last_q;
	assign out_valid     = out_valid_q;

endmodule

>>> hdl/wsd_checker.sv
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks for the WebSocket frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module wsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] payload_byte,
	input logic [1:0] frame_kind,
	input logic       last_of_frame,
	input logic       out_valid,
	input logic       out_stall
);

	// A stalled result item keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_byte)
		&& $stable(frame_kind) && $stable(last_of_frame))
		else $error("result item changed while stalled");

	// Only text and binary frames produce items.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_kind == wsd_pkg::KIND_TEXT) || (frame_kind == wsd_pkg::KIND_BINARY))
		else $error("result item with a bad frame kind");

	// The input is never stalled while the result register is empty.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with an empty result register");

	// A fresh result item comes from an accepted item, by way of the input register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result item without a matching accepted item");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);

>>> dv/tb_websocket_frame_deframer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer
// Self-checking testbench for the WebSocket frame deframer. Frames are sent
// one byte per item with random idle gaps, and the sink stalls at random. A
// predictor tracks the parser state for each accepted byte and queues the
// payload items it expects. The checker compares every accepted result with
// the oldest queued item.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer;

	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	typedef enum {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

	typedef struct {
		wsd_pkg::byte_t data;
		logic [1:0]     kind;
		logic           last;
	} payload_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] payload_byte;
	logic [1:0] frame_kind;
	logic       last_of_frame;
	logic       out_valid;
	logic       out_stall = 1'b0;

	// Predicted parser state.
	logic [2:0]  st_phase = wsd_pkg::PH_HDR1;
	logic [3:0]  st_opcode = '0;
	logic        st_masked = 1'b0;
	logic [3:0]  st_ext_left = '0;
	logic [63:0] st_remaining = '0;
	logic [31:0] st_key = '0;
	logic [2:0]  st_key_left = '0;
	logic [1:0]  st_pphase = '0;

	payload_t pending_payload[$];
	int       mismatch_count = 0;
	int       items_sent = 0;
	int       idle_pct = 0;
	int       stall_pct = 0;
	int       stall_left = 0;

	websocket_frame_deframer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_byte      (rx_byte),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.payload_byte (payload_byte),
		.frame_kind   (frame_kind),
		.last_of_frame(last_of_frame),
		.out_valid    (out_valid),
		.out_stall    (out_stall)
	);

	always #5 clk = ~clk;

	function automatic int random_gap_len();
		return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 30);
	endfunction

	function automatic void header_complete();
		st_pphase = '0;
		st_phase = (st_remaining == 0) ? wsd_pkg::PH_HDR1 : wsd_pkg::PH_DATA;
	endfunction

	function automatic void payload_length_known();
		if (st_masked) begin
			st_key_left = wsd_pkg::KEY_BYTES;
			st_phase = wsd_pkg::PH_KEY;
		end else begin
			header_complete();
		end
	endfunction

	task automatic deframe_byte(input wsd_pkg::byte_t b);
		payload_t       item;
		wsd_pkg::byte_t keyb;
		int             sh;
		logic           last;
		case (st_phase)
			wsd_pkg::PH_HDR2: begin
				st_masked = b[7];
				st_remaining = '0;
				if (b[6:0] <= wsd_pkg::LEN7_MAX_SHORT) begin
					st_remaining = {57'd0, b[6:0]};
					st_ext_left = '0;
					payload_length_known();
				end else begin
					st_ext_left = (b[6:0] == wsd_pkg::LEN7_EXT16) ? wsd_pkg::EXT16_BYTES
					                                              : wsd_pkg::EXT64_BYTES;
					st_phase = wsd_pkg::PH_EXTLEN;
				end
			end
			wsd_pkg::PH_EXTLEN: begin
				st_remaining = {st_remaining[55:0], b};
				if (st_ext_left != 0)
					st_ext_left = st_ext_left - 4'd1;
				if (st_ext_left == 0)
					payload_length_known();
			end
			wsd_pkg::PH_KEY: begin
				st_key = {st_key[23:0], b};
				if (st_key_left != 0)
					st_key_left = st_key_left - 3'd1;
				if (st_key_left == 0)
					header_complete();
			end
			wsd_pkg::PH_DATA: begin
				// The first key byte on the wire masks payload index 0.
				sh = 24 - 8 * int'(st_pphase);
				keyb = st_masked ? st_key[sh +: 8] : 8'h00;
				last = (st_remaining <= 1);
				if (st_remaining != 0)
					st_remaining = st_remaining - 64'd1;
				st_pphase = st_pphase + 2'd1;
				if (st_remaining == 0)
					st_phase = wsd_pkg::PH_HDR1;
				if (st_opcode == wsd_pkg::OP_TEXT || st_opcode == wsd_pkg::OP_BINARY) begin
					item.data = b ^ keyb;
					item.kind = st_opcode[1:0];
					item.last = last;
					pending_payload.push_back(item);
				end
			end
			default: begin
				st_opcode = b[3:0] & wsd_pkg::OP_MASK;
				st_phase = wsd_pkg::PH_HDR2;
			end
		endcase
	endtask

	// Called at a falling edge; returns at a falling edge.
	task automatic send_byte(input wsd_pkg::byte_t b);
		int gap;
		gap = ($urandom_range(0, 99) < idle_pct) ? random_gap_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_byte <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		deframe_byte(b);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_seq(input wsd_pkg::byte_t s[$]);
		foreach (s[i])
			send_byte(s[i]);
	endtask

	task automatic wait_for_payload_drain();
		in_valid <= 1'b0;
		while (pending_payload.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic send_random_frame(input bit noisy);
		wsd_pkg::byte_t hdr1;
		logic [63:0]    len;
		len_form_t      form;
		bit             masked;
		int             r;
		r = $urandom_range(0, 99);
		if (noisy)
			hdr1 = 8'($urandom);
		else if (r < 45)
			hdr1 = {4'($urandom), wsd_pkg::OP_TEXT};
		else if (r < 90)
			hdr1 = {4'($urandom), wsd_pkg::OP_BINARY};
		else
			hdr1 = {4'($urandom), 4'($urandom)};
		masked = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 99);
		if (r < 3)
			len = 64'd125;
		else if (r < 6)
			len = 64'($urandom_range(126, 300));
		else
			len = 64'($urandom_range(0, 12));
		r = $urandom_range(0, 99);
		if (len > 125 || r < 18)
			form = (len > 125 || r < 10) ? LEN_EXT16 : LEN_EXT64;
		else
			form = LEN_SHORT;
		send_byte(hdr1);
		case (form)
			LEN_SHORT: send_byte({masked, len[6:0]});
			LEN_EXT16: begin
				send_byte({masked, wsd_pkg::LEN7_EXT16});
				send_byte(len[15:8]);
				send_byte(len[7:0]);
			end
			default: begin
				send_byte({masked, LEN7_EXT64});
				for (int i = 7; i >= 0; i--)
					send_byte(len[8*i +: 8]);
			end
		endcase
		if (masked)
			repeat (4) send_byte(8'($urandom));
		repeat (int'(len)) send_byte(8'($urandom));
	endtask

	task automatic test_text_and_binary();
		wsd_pkg::byte_t seq[$];
		// Unmasked text frame carrying both extreme byte values.
		seq = '{8'h81, 8'h02, 8'h00, 8'hFF};
		send_seq(seq);
		// Masked binary frame with FIN clear and all RSV bits set.
		seq = '{8'h72, 8'h85, 8'hA5, 8'h5A, 8'hFF, 8'h00,
			8'h11, 8'h22, 8'h33, 8'h44, 8'h55};
		send_seq(seq);
		wait_for_payload_drain();
	endtask

	task automatic test_zero_length_and_dropped();
		wsd_pkg::byte_t seq[$];
		seq = '{8'h81, 8'h00};
		send_seq(seq);
		// Ping payload is consumed without a result.
		seq = '{8'h89, 8'h01, 8'h55};
		send_seq(seq);
		// Masked zero-length continuation: the key still arrives.
		seq = '{8'h80, 8'h80, 8'h01, 8'h02, 8'h03, 8'h04};
		send_seq(seq);
		seq = '{8'h81, 8'h01, 8'h7E};
		send_seq(seq);
		wait_for_payload_drain();
	endtask

	task automatic test_short_extended_length();
		wsd_pkg::byte_t seq[$];
		// A 16-bit length below 126 is taken as given.
		seq = '{8'h82, 8'h7E, 8'h00, 8'h01, 8'hAB};
		send_seq(seq);
		wait_for_payload_drain();
	endtask

	task automatic test_random_traffic(input int n_items, input int idle, input int stall);
		int target;
		idle_pct = idle;
		stall_pct = stall;
		target = items_sent + n_items;
		while (items_sent < target)
			send_random_frame($urandom_range(0, 99) < 8);
		wait_for_payload_drain();
	endtask

	// The top length bit is counted, so this frame never ends; it runs last.
	task automatic test_full_width_length();
		wsd_pkg::byte_t seq[$];
		idle_pct = 20;
		stall_pct = 20;
		seq = '{8'h81, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03,
			8'hDE, 8'hAD, 8'hBE, 8'hEF};
		send_seq(seq);
		repeat (6) send_byte(8'($urandom));
		wait_for_payload_drain();
	endtask

	always @(negedge clk) begin
		if (stall_left == 0 && $urandom_range(0, 99) < stall_pct)
			stall_left = random_gap_len();
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		payload_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_payload.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected item: byte %h kind %0d last %b", $time,
					payload_byte, frame_kind, last_of_frame);
			end else begin
				want = pending_payload.pop_front();
				if (payload_byte !== want.data) begin
					mismatch_count++;
					$display("%0t: payload_byte expected %h actual %h", $time,
						want.data, payload_byte);
				end
				if (frame_kind !== want.kind) begin
					mismatch_count++;
					$display("%0t: frame_kind expected %0d actual %0d", $time,
						want.kind, frame_kind);
				end
				if (last_of_frame !== want.last) begin
					mismatch_count++;
					$display("%0t: last_of_frame expected %b actual %b", $time,
						want.last, last_of_frame);
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("tb_websocket_frame_deframer: done, errors");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		idle_pct = 20;
		stall_pct = 20;
		test_text_and_binary();
		test_zero_length_and_dropped();
		test_short_extended_length();
		test_random_traffic(450, 30, 30);
		test_random_traffic(280, 0, 0);
		test_random_traffic(200, 60, 60);
		test_full_width_length();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_websocket_frame_deframer: done, clean");
		else
			$display("tb_websocket_frame_deframer: done, errors");
		$finish;
	end

endmodule

>>> sim.f
hdl/wsd_pkg.sv
hdl/websocket_frame_deframer.sv
hdl/wsd_checker.sv
dv/tb_websocket_frame_deframer.sv
